// File: hw/rtl/rcps_pkg.sv
// Shared types, constants and sequencer states for the charged particle ring block.
package rcps_pkg;

  localparam int unsigned NUM_PARTICLES_DEF = 5;
  localparam int unsigned NUM_LEDS_DEF      = 85;

  localparam int unsigned POS_W     = 24;
  localparam int unsigned VEL_W     = 40;
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned PIDX_W    = 3;
  localparam int unsigned LED_IDX_W = 7;

  localparam int unsigned POS_HALF = 2 ** (POS_W - 1);
  localparam int unsigned POS_FULL = 2 ** POS_W;

  localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd256;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // shared multiplier: signed a times unsigned b
  localparam int unsigned MUL_A_W = 29;
  localparam int unsigned MUL_B_W = 24;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W + 1;

  // dt = floor(speed * elapsed / 2560) = floor((prod >> 9) / 5)
  localparam int unsigned PROD_W       = SPEED_W + ELAPSED_W;
  localparam int unsigned DT_PRE_SHIFT = 9;
  localparam int unsigned RECIP_SHIFT  = 26;
  localparam logic [MUL_B_W-1:0] RECIP5 = 24'hCCCCCD;
  localparam int unsigned DT_W         = 21;

  // force sum, worst case fifteen neighbors at half a ring
  localparam int unsigned SUM_W = 28;

  // dv = floor((1000 - S*dt) / 2000) = floor(((1000 - S*dt) >>> 4) / 125)
  localparam int unsigned Y_W        = 50;
  localparam int unsigned ROUND_BIAS = 1000;
  localparam int unsigned PRE_SHIFT  = 4;
  localparam int unsigned Z_W        = Y_W - PRE_SHIFT;

  localparam int unsigned DIV_W     = 48;
  localparam int unsigned DIV_D     = 125;
  localparam int unsigned DIV_STEP  = 4;
  localparam int unsigned DIV_STEPS = DIV_W / DIV_STEP;
  localparam int unsigned REM_W     = $clog2(DIV_D);

  typedef struct packed {
    logic                 kind;
    logic [PIDX_W-1:0]    particle;
    logic [POS_W-1:0]     position;
    logic                 positive;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } part_req_t;

  typedef struct packed {
    logic [LED_IDX_W-1:0] led_index;
    logic                 polarity;
    logic                 last;
  } led_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DT_PROD,
    ST_DT_RECIP,
    ST_DT_SET,
    ST_FETCH,
    ST_SUM,
    ST_FMUL,
    ST_FDIV,
    ST_FWAIT,
    ST_VUPD,
    ST_PMUL,
    ST_PUPD,
    ST_LMUL,
    ST_LED
  } state_e;

endpackage

// File: hw/rtl/rcps_mul.sv
// Shared registered multiplier: signed operand times unsigned operand.
module rcps_mul (
  input  logic                                     clk_i,
  input  logic signed [rcps_pkg::MUL_A_W-1:0]      a_i,
  input  logic        [rcps_pkg::MUL_B_W-1:0]      b_i,
  output logic signed [rcps_pkg::MUL_P_W-1:0]      p_o
);

  logic signed [rcps_pkg::MUL_P_W-1:0] p_d;
  logic signed [rcps_pkg::MUL_P_W-1:0] p_q;

  assign p_d = a_i * $signed({1'b0, b_i});

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// File: hw/rtl/rcps_div.sv
// Iterative unsigned divider by a constant, four quotient bits per cycle.
module rcps_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [rcps_pkg::DIV_W-1:0]       dividend_i,
  output logic                             done_o,
  output logic [rcps_pkg::DIV_W-1:0]       quotient_o
);

  localparam int unsigned DIV_W = rcps_pkg::DIV_W;
  localparam int unsigned REM_W = rcps_pkg::REM_W;
  localparam int unsigned CNT_W = $clog2(rcps_pkg::DIV_STEPS);
  localparam logic [REM_W:0] DIVISOR = (REM_W + 1)'(rcps_pkg::DIV_D);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(rcps_pkg::DIV_STEPS - 1);

  logic [DIV_W-1:0] work_q, work_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  // work register shifts dividend bits out the top and quotient bits in the bottom
  always_comb begin
    logic [REM_W:0]   trial;
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] work;
    rem  = rem_q;
    work = work_q;
    for (int k = 0; k < rcps_pkg::DIV_STEP; k++) begin
      trial = {rem, work[DIV_W-1]};
      work  = {work[DIV_W-2:0], 1'b0};
      if (trial >= DIVISOR) begin
        trial   = trial - DIVISOR;
        work[0] = 1'b1;
      end
      rem = trial[REM_W-1:0];
    end
    rem_d  = rem;
    work_d = work;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = work_q;

endmodule

// File: hw/rtl/ring_charged_particle_step.sv
// Charged particles on a ring: load/tick sequencer, particle state and datapath.
//
// Input channel (in_valid_i/in_ready_o, in_req_i): a load request places one
// particle, sets its charge and clears its velocity; it gives no result. A load
// with an index past the last particle is dropped. A tick request advances all
// particles and yields one result per particle, in index order, with last set
// on the final one. Output channel (out_valid_o/out_ready_i, out_req_o): one
// output register. speed is written through cfg_we_i/cfg_wdata_i; the user is
// to write it only while the block is idle; the block does not enforce this.
//
// A tick first computes dt on the shared multiplier, then runs a force pass
// per particle: pairwise sums over all particles, a multiply by dt and a
// divide on the shared divider, then the velocity update; then, per particle,
// the move and LED lookup on the shared multiplier. in_ready_o is high only when
// idle. A stalled receiver holds the sequencer at the pending result; the
// last result may wait in the output register while a new request is taken.
// Reset clears all positions, velocities and charges and sets speed to 1.0.
module ring_charged_particle_step #(
  parameter int unsigned NUM_PARTICLES = rcps_pkg::NUM_PARTICLES_DEF,
  parameter int unsigned NUM_LEDS      = rcps_pkg::NUM_LEDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rcps_pkg::SPEED_W-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  rcps_pkg::part_req_t             in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rcps_pkg::led_req_t              out_req_o
);

  localparam int unsigned POS_W   = rcps_pkg::POS_W;
  localparam int unsigned VEL_W   = rcps_pkg::VEL_W;
  localparam int unsigned SUM_W   = rcps_pkg::SUM_W;
  localparam int unsigned DT_W    = rcps_pkg::DT_W;
  localparam int unsigned MUL_A_W = rcps_pkg::MUL_A_W;
  localparam int unsigned MUL_B_W = rcps_pkg::MUL_B_W;
  localparam int unsigned MUL_P_W = rcps_pkg::MUL_P_W;
  localparam int unsigned Y_W     = rcps_pkg::Y_W;
  localparam int unsigned Z_W     = rcps_pkg::Z_W;
  localparam int unsigned DIV_W   = rcps_pkg::DIV_W;
  localparam int unsigned IDX_W   = $clog2(NUM_PARTICLES);
  localparam int unsigned LED_W   = $clog2(NUM_LEDS + 1);
  localparam int unsigned RND_W   = POS_W + LED_W;

  localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(NUM_PARTICLES - 1);
  localparam logic signed [POS_W:0]   HALF_S   = (POS_W + 1)'(rcps_pkg::POS_HALF);
  localparam logic [POS_W:0]          FULL_U   = (POS_W + 1)'(rcps_pkg::POS_FULL);
  localparam logic [VEL_W-1:0]        VEL_MAX  = {1'b0, {(VEL_W - 1){1'b1}}};
  localparam logic [VEL_W-1:0]        VEL_MIN  = {1'b1, {(VEL_W - 1){1'b0}}};

  rcps_pkg::state_e state_q, state_d;

  logic [rcps_pkg::SPEED_W-1:0]   speed_q;
  logic [rcps_pkg::ELAPSED_W-1:0] elapsed_q;
  logic [DT_W-1:0]                dt_q;
  logic [IDX_W-1:0]               i_q, j_q;
  logic [POS_W-1:0]               xi_q;
  logic                           ci_q;
  logic signed [SUM_W-1:0]        sum_q;
  logic                           neg_q;

  logic [POS_W-1:0] pos_q [NUM_PARTICLES];
  logic [VEL_W-1:0] vel_q [NUM_PARTICLES];
  logic             chg_q [NUM_PARTICLES];

  logic                 out_valid_q;
  rcps_pkg::led_req_t   out_req_q;

  logic [IDX_W-1:0] rd_idx;
  logic [POS_W-1:0] pos_rd;
  logic [VEL_W-1:0] vel_rd;
  logic             chg_rd;

  logic             in_fire;
  logic             load_hit;
  logic [IDX_W-1:0] load_idx;
  logic             out_free;
  logic             out_load;
  logic             div_start;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;
  logic [DIV_W-1:0] div_dividend;

  logic signed [MUL_A_W-1:0] mul_a;
  logic        [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  logic signed [POS_W:0]   dist_raw;
  logic        [POS_W:0]   dist_bits;
  logic signed [SUM_W-1:0] dist_ext;
  logic signed [SUM_W-1:0] sum_next;

  logic [Y_W-1:0]   y_val;
  logic [Z_W-1:0]   z_val;
  logic             z_neg;
  logic [Z_W-2:0]   u_val;

  logic [VEL_W-1:0] dv_mag;
  logic [VEL_W-1:0] dv;
  logic [VEL_W:0]   vsum;
  logic [VEL_W-1:0] vel_new;

  logic [POS_W-1:0] pos_new;
  logic [RND_W-1:0] led_rnd;
  logic [LED_W-1:0] led_full;
  logic [LED_W-1:0] led_mod;
  logic [15:0]      led_ext;

  // ---------------------------------------------------------------- shared units
  rcps_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  rcps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // ---------------------------------------------------------------- particle read
  assign rd_idx = (state_q == rcps_pkg::ST_SUM) ? j_q : i_q;
  assign pos_rd = pos_q[rd_idx];
  assign vel_rd = vel_q[rd_idx];
  assign chg_rd = chg_q[rd_idx];

  assign in_fire  = in_valid_i && in_ready_o;
  assign load_hit = in_fire && (in_req_i.kind == rcps_pkg::KIND_LOAD) &&
                    (32'(in_req_i.particle) < NUM_PARTICLES);
  assign load_idx = IDX_W'(in_req_i.particle);
  assign out_free = !out_valid_q || out_ready_i;

  // ---------------------------------------------------------------- datapath math
  // wrapped distance; exactly half a ring keeps its sign
  always_comb begin
    dist_raw = $signed({1'b0, pos_rd}) - $signed({1'b0, xi_q});
    if (dist_raw > HALF_S) begin
      dist_bits = (POS_W + 1)'(dist_raw) - FULL_U;
    end else if (dist_raw < -HALF_S) begin
      dist_bits = (POS_W + 1)'(dist_raw) + FULL_U;
    end else begin
      dist_bits = (POS_W + 1)'(dist_raw);
    end
    dist_ext = SUM_W'($signed(dist_bits));
    sum_next = (ci_q == chg_rd) ? (sum_q + dist_ext) : (sum_q - dist_ext);
  end

  // floor division of a negative value runs on its complement
  assign y_val        = Y_W'(rcps_pkg::ROUND_BIAS) - mul_p[Y_W-1:0];
  assign z_val        = y_val[Y_W-1:rcps_pkg::PRE_SHIFT];
  assign z_neg        = z_val[Z_W-1];
  assign u_val        = z_neg ? ~z_val[Z_W-2:0] : z_val[Z_W-2:0];
  assign div_dividend = DIV_W'(u_val);

  assign dv_mag  = div_quo[VEL_W-1:0];
  assign dv      = neg_q ? ~dv_mag : dv_mag;
  assign vsum    = {vel_rd[VEL_W-1], vel_rd} + {dv[VEL_W-1], dv};
  assign vel_new = (vsum[VEL_W] != vsum[VEL_W-1]) ?
                   (vsum[VEL_W] ? VEL_MIN : VEL_MAX) : vsum[VEL_W-1:0];

  assign pos_new  = pos_rd + mul_p[POS_W-1:0];
  assign led_rnd  = mul_p[RND_W-1:0] + RND_W'(rcps_pkg::POS_HALF);
  assign led_full = led_rnd[RND_W-1:POS_W];
  assign led_mod  = (led_full == LED_W'(NUM_LEDS)) ? '0 : led_full;
  assign led_ext  = 16'(led_mod);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rcps_pkg::ST_IDLE: begin
        if (in_valid_i && (in_req_i.kind == rcps_pkg::KIND_TICK)) begin
          state_d = rcps_pkg::ST_DT_PROD;
        end
      end
      rcps_pkg::ST_DT_PROD:  state_d = rcps_pkg::ST_DT_RECIP;
      rcps_pkg::ST_DT_RECIP: state_d = rcps_pkg::ST_DT_SET;
      rcps_pkg::ST_DT_SET:   state_d = rcps_pkg::ST_FETCH;
      rcps_pkg::ST_FETCH:    state_d = rcps_pkg::ST_SUM;
      rcps_pkg::ST_SUM: begin
        if (j_q == LAST_IDX) begin
          state_d = rcps_pkg::ST_FMUL;
        end
      end
      rcps_pkg::ST_FMUL: state_d = rcps_pkg::ST_FDIV;
      rcps_pkg::ST_FDIV: state_d = rcps_pkg::ST_FWAIT;
      rcps_pkg::ST_FWAIT: begin
        if (div_done) begin
          state_d = rcps_pkg::ST_VUPD;
        end
      end
      rcps_pkg::ST_VUPD: begin
        state_d = (i_q == LAST_IDX) ? rcps_pkg::ST_PMUL : rcps_pkg::ST_FETCH;
      end
      rcps_pkg::ST_PMUL: state_d = rcps_pkg::ST_PUPD;
      rcps_pkg::ST_PUPD: state_d = rcps_pkg::ST_LMUL;
      rcps_pkg::ST_LMUL: state_d = rcps_pkg::ST_LED;
      rcps_pkg::ST_LED: begin
        if (out_free) begin
          state_d = (i_q == LAST_IDX) ? rcps_pkg::ST_IDLE : rcps_pkg::ST_PMUL;
        end
      end
      default: state_d = rcps_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- state outputs
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_q)
      rcps_pkg::ST_IDLE: in_ready_o = 1'b1;
      rcps_pkg::ST_DT_PROD: begin
        mul_a = MUL_A_W'(speed_q);
        mul_b = MUL_B_W'(elapsed_q);
      end
      rcps_pkg::ST_DT_RECIP: begin
        mul_a = MUL_A_W'(mul_p[rcps_pkg::PROD_W-1:rcps_pkg::DT_PRE_SHIFT]);
        mul_b = rcps_pkg::RECIP5;
      end
      rcps_pkg::ST_FMUL: begin
        mul_a = MUL_A_W'(sum_q);
        mul_b = MUL_B_W'(dt_q);
      end
      rcps_pkg::ST_FDIV: div_start = 1'b1;
      rcps_pkg::ST_PMUL: begin
        mul_a = MUL_A_W'(vel_rd[POS_W-1:0]);
        mul_b = MUL_B_W'(dt_q);
      end
      rcps_pkg::ST_LMUL: begin
        mul_a = MUL_A_W'(NUM_LEDS);
        mul_b = pos_rd;
      end
      rcps_pkg::ST_LED: begin
        mul_a    = MUL_A_W'(NUM_LEDS);
        mul_b    = pos_rd;
        out_load = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------- control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rcps_pkg::ST_IDLE;
      speed_q     <= rcps_pkg::SPEED_RESET;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NUM_PARTICLES; k++) begin
        pos_q[k] <= '0;
        vel_q[k] <= '0;
        chg_q[k] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        speed_q <= cfg_wdata_i;
      end
      if (load_hit) begin
        pos_q[load_idx] <= in_req_i.position;
        chg_q[load_idx] <= in_req_i.positive;
        vel_q[load_idx] <= '0;
      end
      if (in_fire) begin
        i_q <= '0;
      end
      if (state_q == rcps_pkg::ST_FETCH) begin
        j_q <= '0;
      end
      if (state_q == rcps_pkg::ST_SUM) begin
        j_q <= j_q + IDX_W'(1);
      end
      if (state_q == rcps_pkg::ST_VUPD) begin
        vel_q[i_q] <= vel_new;
        i_q        <= (i_q == LAST_IDX) ? '0 : (i_q + IDX_W'(1));
      end
      if (state_q == rcps_pkg::ST_PUPD) begin
        pos_q[i_q] <= pos_new;
      end
      if (out_load && (i_q != LAST_IDX)) begin
        i_q <= i_q + IDX_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- working registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      elapsed_q <= in_req_i.elapsed_ms;
    end
    if (state_q == rcps_pkg::ST_DT_SET) begin
      dt_q <= mul_p[rcps_pkg::RECIP_SHIFT +: DT_W];
    end
    if (state_q == rcps_pkg::ST_FETCH) begin
      xi_q  <= pos_rd;
      ci_q  <= chg_rd;
      sum_q <= '0;
    end
    if (state_q == rcps_pkg::ST_SUM) begin
      sum_q <= sum_next;
    end
    if (state_q == rcps_pkg::ST_FDIV) begin
      neg_q <= z_neg;
    end
    if (out_load) begin
      out_req_q.led_index <= led_ext[rcps_pkg::LED_IDX_W-1:0];
      out_req_q.polarity  <= chg_rd;
      out_req_q.last      <= (i_q == LAST_IDX);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

// File: tb/rcps_led_checker.sv
// Checker for the charged particle ring: mirrors particle state and compares LED results.
module rcps_led_checker #(
  parameter int unsigned NUM_PARTICLES = rcps_pkg::NUM_PARTICLES_DEF,
  parameter int unsigned NUM_LEDS      = rcps_pkg::NUM_LEDS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rcps_pkg::SPEED_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  rcps_pkg::part_req_t          in_req_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  rcps_pkg::led_req_t           out_req_i,
  output int                           pending_o,
  output int                           errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rcps_pkg::*;

  localparam longint HalfRing = longint'(POS_HALF);
  localparam longint FullRing = longint'(POS_FULL);
  localparam longint VelMax   = (longint'(1) <<< (VEL_W - 1)) - 1;
  localparam longint VelMin   = -VelMax - 1;

  logic [SPEED_W-1:0]      speed_q;
  logic [POS_W-1:0]        ring_pos [NUM_PARTICLES];
  logic signed [VEL_W-1:0] ring_vel [NUM_PARTICLES];
  logic                    ring_chg [NUM_PARTICLES];
  led_req_t                pending_leds [$];
  int                      err_cnt;
  int                      led_seen;

  function automatic longint div_floor(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den != 0) && (num < 0)) q = q - 1;
    return q;
  endfunction

  // One tick: forces from old positions, then velocities, then moves and LED lookup.
  task automatic advance_particles(input logic [ELAPSED_W-1:0] elapsed);
    longint   dt;
    longint   s;
    longint   d;
    longint   v;
    longint   nx;
    longint   led;
    longint   dv [NUM_PARTICLES];
    led_req_t res;
    dt = (longint'(speed_q) * longint'(elapsed)) / 2560;
    for (int i = 0; i < NUM_PARTICLES; i++) begin
      s = 0;
      for (int j = 0; j < NUM_PARTICLES; j++) begin
        if (j != i) begin
          d = longint'(ring_pos[j]) - longint'(ring_pos[i]);
          if (d > HalfRing) d = d - FullRing;
          else if (d < -HalfRing) d = d + FullRing;
          s = (ring_chg[i] == ring_chg[j]) ? s + d : s - d;
        end
      end
      dv[i] = div_floor(1000 - s * dt, 2000);
    end
    for (int i = 0; i < NUM_PARTICLES; i++) begin
      v = longint'(ring_vel[i]) + dv[i];
      if (v > VelMax) v = VelMax;
      else if (v < VelMin) v = VelMin;
      ring_vel[i] = v[VEL_W-1:0];
    end
    for (int i = 0; i < NUM_PARTICLES; i++) begin
      nx = longint'(ring_pos[i]) + longint'(ring_vel[i]) * dt;
      ring_pos[i] = nx[POS_W-1:0];
    end
    for (int i = 0; i < NUM_PARTICLES; i++) begin
      led = ((longint'(NUM_LEDS) * longint'(ring_pos[i]) + HalfRing) >> POS_W)
            % longint'(NUM_LEDS);
      res.led_index = led[LED_IDX_W-1:0];
      res.polarity  = ring_chg[i];
      res.last      = (i == NUM_PARTICLES - 1);
      pending_leds.push_back(res);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    led_req_t want;
    if (!rst_ni) begin
      speed_q = SPEED_RESET;
      for (int i = 0; i < NUM_PARTICLES; i++) begin
        ring_pos[i] = '0;
        ring_vel[i] = '0;
        ring_chg[i] = 1'b0;
      end
      pending_leds.delete();
      err_cnt  = 0;
      led_seen = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_leds.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("[%0t] LED request %0d with none expected: led %0d pol %0b last %0b",
                     $realtime, led_seen, out_req_i.led_index, out_req_i.polarity,
                     out_req_i.last);
        end else begin
          want = pending_leds.pop_front();
          if (out_req_i.led_index !== want.led_index || out_req_i.polarity !== want.polarity
              || out_req_i.last !== want.last) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("[%0t] LED request %0d: expected led %0d pol %0b last %0b, got %0d %0b %0b",
                       $realtime, led_seen, want.led_index, want.polarity, want.last,
                       out_req_i.led_index, out_req_i.polarity, out_req_i.last);
          end
        end
        led_seen++;
      end
      if (cfg_we_i) speed_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        if (in_req_i.kind == KIND_TICK) begin
          advance_particles(in_req_i.elapsed_ms);
        end else if (in_req_i.particle < NUM_PARTICLES) begin
          ring_pos[in_req_i.particle] = in_req_i.position;
          ring_chg[in_req_i.particle] = in_req_i.positive;
          ring_vel[in_req_i.particle] = '0;
        end
      end
      pending_o <= pending_leds.size();
      errors_o  <= err_cnt;
    end
  end

endmodule

// File: tb/tb_ring_charged_particle_step.sv
// Testbench top for the charged particle ring: clock, reset, request stimulus and verdict.
module tb_ring_charged_particle_step;
  timeunit 1ns;
  timeprecision 1ps;
  import rcps_pkg::*;

  localparam int unsigned NumParticles = NUM_PARTICLES_DEF;
  localparam int          CycleLimit   = 400000;
  localparam int          SettleCycles = 16;
  localparam int          TickCycles   = 150;
  localparam int          PhaseQuota   = 28;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [SPEED_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  part_req_t          in_req_i    = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  led_req_t           out_req_o;

  int pending;
  int errors;
  bit calm     = 1'b0;
  int cycles   = 0;
  int out_hold = 0;
  int n_ticks  = 0;
  int n_loads  = 0;
  int n_dropped = 0;
  int n_speeds = 0;

  logic [SPEED_W-1:0] phase_speed [6];

  ring_charged_particle_step u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

  rcps_led_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_i   (out_req_o),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d LED requests outstanding", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (calm) return 0;
    return $urandom_range(0, 7);
  endfunction

  // receiver stall counts down only while a result is on offer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid_o && out_ready_i) out_hold = draw_gap();
      if (out_hold > 0) begin
        out_ready_i <= 1'b0;
        if (out_valid_o) out_hold--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic part_req_t load_req(input int idx, input logic [POS_W-1:0] pos,
                                         input logic sign);
    logic [63:0] junk;
    part_req_t   r;
    junk = {$urandom(), $urandom()};
    r = junk[$bits(part_req_t)-1:0];
    r.kind     = KIND_LOAD;
    r.particle = idx[PIDX_W-1:0];
    r.position = pos;
    r.positive = sign;
    return r;
  endfunction

  function automatic part_req_t tick_req(input logic [ELAPSED_W-1:0] elapsed);
    logic [63:0] junk;
    part_req_t   r;
    junk = {$urandom(), $urandom()};
    r = junk[$bits(part_req_t)-1:0];
    r.kind       = KIND_TICK;
    r.elapsed_ms = elapsed;
    return r;
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    case ($urandom_range(0, 7))
      0:       return POS_W'($urandom_range(0, 15));
      1:       return 24'hFFFFFF - POS_W'($urandom_range(0, 15));
      2:       return 24'h7FFFF8 + POS_W'($urandom_range(0, 15));
      default: return POS_W'($urandom());
    endcase
  endfunction

  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return ELAPSED_W'($urandom_range(0, 40));
    if (r < 9) return ELAPSED_W'($urandom_range(0, 1000));
    return ELAPSED_W'($urandom());
  endfunction

  task automatic send_req(input part_req_t req);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (req.kind == KIND_TICK) n_ticks++;
    else if (req.particle < NumParticles) n_loads++;
    else n_dropped++;
  endtask

  task automatic wait_drained(input int settle);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_speed(input logic [SPEED_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    n_speeds++;
  endtask

  task automatic random_phase(input int quota);
    int start;
    int r;
    int j;
    int t;
    int order [NumParticles];
    start = n_ticks + n_loads;
    while (n_ticks + n_loads - start < quota) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        // full reload in shuffled order, then a run of ticks
        for (int i = 0; i < NumParticles; i++) order[i] = i;
        for (int i = NumParticles - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = order[i];
          order[i] = order[j];
          order[j] = t;
        end
        for (int i = 0; i < NumParticles; i++)
          send_req(load_req(order[i], pick_pos(), $urandom_range(0, 1)));
        repeat ($urandom_range(2, 6)) send_req(tick_req(pick_elapsed()));
      end else if (r < 9) begin
        if ($urandom_range(0, 1))
          send_req(load_req($urandom_range(0, 7), pick_pos(), $urandom_range(0, 1)));
        else
          send_req(tick_req(ELAPSED_W'($urandom())));
      end else begin
        // partial reload, then one tick
        repeat ($urandom_range(1, NumParticles - 1))
          send_req(load_req($urandom_range(0, NumParticles - 1), pick_pos(),
                            $urandom_range(0, 1)));
        send_req(tick_req(pick_elapsed()));
      end
    end
  endtask

  initial begin
    phase_speed[0] = 16'd0;
    phase_speed[1] = 16'hFFFF;
    phase_speed[2] = 16'd1;
    phase_speed[3] = SPEED_W'($urandom());
    phase_speed[4] = SPEED_RESET;
    phase_speed[5] = SPEED_W'($urandom_range(128, 1024));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pass at reset speed
    send_req(tick_req(16'd0));
    send_req(load_req(0, 24'h000000, 1'b1));
    send_req(load_req(1, 24'hFFFFFF, 1'b0));
    send_req(load_req(2, 24'h800000, 1'b1));
    send_req(load_req(3, 24'h400000, 1'b0));
    send_req(load_req(4, 24'hC00000, 1'b1));
    send_req(load_req(5, 24'hFFFFFF, 1'b1));
    send_req(load_req(7, 24'hABCDEF, 1'b0));
    send_req(tick_req(16'd0));
    send_req(tick_req(16'd9));
    send_req(tick_req(16'd10));
    send_req(tick_req(16'hFFFF));
    send_req(load_req(2, 24'h000001, 1'b0));
    send_req(tick_req(16'd40));

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained(SettleCycles);
      calm = (ph == 2);
      write_speed(phase_speed[ph]);
      send_req(tick_req(16'hFFFF));
      random_phase(PhaseQuota);
    end
    calm = 1'b0;

    wait_drained(TickCycles);
    $display("Ran %0d ticks and %0d loads (%0d out-of-range loads dropped) over %0d speeds;",
             n_ticks, n_loads, n_dropped, n_speeds);
    $display("%0d LED requests were checked against the predicted particle motion.",
             n_ticks * NumParticles);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
